// ===== hdl/gap_buffer_line_editor_defines.svh =====
// ----------------------------------------------------------------------------
// gap_buffer_line_editor_defines
// Assertion helpers for the gap buffer line editor.
// ----------------------------------------------------------------------------
`ifndef GAP_BUFFER_LINE_EDITOR_DEFINES_SVH
`define GAP_BUFFER_LINE_EDITOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define GBLE_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`define GBLE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define GBLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define GBLE_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define GBLE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define GBLE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/gble_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gble_pkg
// Shared constants for the gap buffer line editor: field widths, command
// codes and the default buffer size.
// ----------------------------------------------------------------------------
package gble_pkg;

    localparam int CAPACITY_DEFAULT = 1024;

    localparam int KIND_W = 3;
    localparam int CH_W   = 8;
    localparam int IDX_W  = 10;
    localparam int CNT_W  = 11;

    localparam logic [KIND_W-1:0] KIND_LEFT   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RIGHT  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BACK   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

endpackage

// ===== hdl/gble_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gble_cmd_if / gble_res_if
// Valid/ready channels for editor commands and their result words.
// ----------------------------------------------------------------------------
interface gble_cmd_if;
    import gble_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [CH_W-1:0]   ch;
    logic [IDX_W-1:0]  read_index;

    modport source (output valid, output kind, output ch, output read_index, input ready);
    modport sink   (input valid, input kind, input ch, input read_index, output ready);
endinterface

interface gble_res_if;
    import gble_pkg::*;

    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  read_char;
    logic             read_valid;
    logic             overflow;
    logic [CNT_W-1:0] text_length;
    logic [CNT_W-1:0] cursor_pos;

    modport source (output valid, output read_char, output read_valid, output overflow,
                    output text_length, output cursor_pos, input ready);
    modport sink   (input valid, input read_char, input read_valid, input overflow,
                    input text_length, input cursor_pos, output ready);
endinterface

// ===== hdl/gble_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gble_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gble_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/gap_buffer_line_editor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_buffer_line_editor
// One-line text buffer with a cursor, held as a gap buffer in a single RAM.
//
//   channel  role  word
//   cmd      sink  kind, ch, read_index
//   res      src   read_char, read_valid, overflow, text_length, cursor_pos
//
// Every command runs through two states: the accept in S_IDLE issues the RAM
// read, and S_EXEC writes back across the gap and loads the result register.
// The RAM's single read port and its registered read set this split.
// A full result register stalls S_EXEC; cmd is taken only when idle.
// Reset clears the counts; the RAM is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
`include "gap_buffer_line_editor_defines.svh"

module gap_buffer_line_editor #(
    parameter int CAPACITY = gble_pkg::CAPACITY_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    gble_cmd_if.sink          cmd,
    gble_res_if.source        res
);
    import gble_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > IDX_W) ? CW : IDX_W) + 1;
    localparam int SW = ((CW + 1) > CNT_W) ? (CW + 1) : CNT_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     left_reg, left_next;
    logic [CW-1:0]     right_reg, right_next;
    logic [KIND_W-1:0] kind_reg;
    logic [CH_W-1:0]   ch_reg;
    logic [IDX_W-1:0]  idx_reg;

    logic              out_valid_reg;
    logic [CH_W-1:0]   rchar_reg, rchar_next;
    logic              rvalid_reg, rvalid_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  len_reg;
    logic [CNT_W-1:0]  pos_reg;

    logic              accept;
    logic              done;
    logic [AW-1:0]     rd_addr;
    logic [CH_W-1:0]   rd_data;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [CH_W-1:0]   wr_data;

    logic [XW-1:0]     in_idx_x, left_x, right_x, top_x, rel_x;
    logic [XW-1:0]     ex_idx_x, sum_x;
    logic [CW:0]       fill;
    logic [SW-1:0]     len_w, pos_w;

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign done      = (state_reg == S_EXEC) && (!out_valid_reg || res.ready);

    // read address, from the live command and the settled counts
    assign left_x   = XW'(left_reg);
    assign right_x  = XW'(right_reg);
    assign in_idx_x = XW'(cmd.read_index);
    assign top_x    = CAP_X - right_x;
    assign rel_x    = in_idx_x - left_x;

    always_comb
    begin
        case (cmd.kind)
            KIND_LEFT:  rd_addr = AW'(left_reg - CW'(1));
            KIND_RIGHT: rd_addr = AW'(CAP_C - right_reg);
            KIND_READ:
            begin
                if (in_idx_x < left_x)
                    rd_addr = AW'(in_idx_x);
                else
                    rd_addr = AW'(top_x + rel_x);
            end
            default:    rd_addr = '0;
        endcase
    end

    gble_ram #(
        .WIDTH (CH_W),
        .DEPTH (CAPACITY)
    ) u_text_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign ex_idx_x = XW'(idx_reg);
    assign sum_x    = left_x + right_x;
    assign fill     = {1'b0, left_reg} + {1'b0, right_reg};

    always_comb
    begin
        left_next   = left_reg;
        right_next  = right_reg;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = rd_data;
        rchar_next  = '0;
        rvalid_next = 1'b0;
        ovf_next    = 1'b0;
        case (kind_reg)
            KIND_LEFT:
            begin
                if (left_reg != '0)
                begin
                    left_next  = left_reg - CW'(1);
                    right_next = right_reg + CW'(1);
                    wr_en      = done;
                    wr_addr    = AW'(CAP_C - right_reg - CW'(1));
                end
            end
            KIND_RIGHT:
            begin
                if (right_reg != '0)
                begin
                    left_next  = left_reg + CW'(1);
                    right_next = right_reg - CW'(1);
                    wr_en      = done;
                    wr_addr    = AW'(left_reg);
                end
            end
            KIND_BACK:
            begin
                if (left_reg != '0)
                    left_next = left_reg - CW'(1);
            end
            KIND_INSERT:
            begin
                if (fill < (CW+1)'(CAPACITY))
                begin
                    left_next = left_reg + CW'(1);
                    wr_en     = done;
                    wr_addr   = AW'(left_reg);
                    wr_data   = ch_reg;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            KIND_READ:
            begin
                if (ex_idx_x < sum_x)
                begin
                    rchar_next  = rd_data;
                    rvalid_next = 1'b1;
                end
            end
            default:
            begin
                left_next = left_reg;
            end
        endcase
    end

    assign len_w = SW'(left_next) + SW'(right_next);
    assign pos_w = SW'(left_next);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_EXEC;
            S_EXEC:  if (done)   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            left_reg      <= '0;
            right_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (done)
            begin
                left_reg      <= left_next;
                right_reg     <= right_next;
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= cmd.kind;
            ch_reg   <= cmd.ch;
            idx_reg  <= cmd.read_index;
        end
        if (done)
        begin
            rchar_reg  <= rchar_next;
            rvalid_reg <= rvalid_next;
            ovf_reg    <= ovf_next;
            len_reg    <= len_w[CNT_W-1:0];
            pos_reg    <= pos_w[CNT_W-1:0];
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.read_char   = rchar_reg;
    assign res.read_valid  = rvalid_reg;
    assign res.overflow    = ovf_reg;
    assign res.text_length = len_reg;
    assign res.cursor_pos  = pos_reg;

    `GBLE_ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill <= (CW+1)'(CAPACITY))
    `GBLE_ASSERT_NEXT(a_accept_exec, clk, rst_n, accept, state_reg == S_EXEC)
    `GBLE_ASSERT_IMPL(a_no_idle_write, clk, rst_n, state_reg == S_IDLE, !wr_en)
    `GBLE_ASSERT_NEXT(a_counts_hold, clk, rst_n, state_reg == S_IDLE, $stable(left_reg) && $stable(right_reg))
    `GBLE_ASSERT_IMPL(a_ovf_full, clk, rst_n, done && ovf_next, fill == (CW+1)'(CAPACITY))

endmodule
